// ===== sv/psc_pkg.sv =====
// Shared types, constants and the seven-segment decode for the press counter.
// Used by the channel interfaces, the press control, the digit cells and the top level.
`default_nettype none

package psc_pkg;

    localparam int COUNT_W   = 14;
    localparam int DIGIT_W   = 4;
    localparam int SEG_W     = 7;
    localparam int POS_OUT_W = 2;
    localparam int HOLD_W    = 8;
    localparam int REG_IDX_W = 1;
    localparam int WDATA_W   = 8;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_HOLD_LIMIT    = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_BLANK_LEADING = 1'd1;

    localparam logic [HOLD_W-1:0]  HOLD_LIMIT_RESET = 8'd20;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX        = 4'd9;

    typedef struct packed {
        logic bump;
        logic clear;
    } psc_cmd_t;

    typedef struct packed {
        logic [SEG_W-1:0]     segments;
        logic [POS_OUT_W-1:0] digit_position;
        logic                 digit_lit;
        logic [COUNT_W-1:0]   count_value;
    } psc_result_t;

    // Segment pattern of one BCD digit, bit 0 is segment a.
    function automatic logic [SEG_W-1:0] psc_seg_code(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] code;
        case (d)
            4'd0:    code = 7'h3f;
            4'd1:    code = 7'h06;
            4'd2:    code = 7'h5b;
            4'd3:    code = 7'h4f;
            4'd4:    code = 7'h66;
            4'd5:    code = 7'h6d;
            4'd6:    code = 7'h7d;
            4'd7:    code = 7'h07;
            4'd8:    code = 7'h7f;
            4'd9:    code = 7'h6f;
            default: code = '0;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== sv/psc_if.sv =====
// Valid/ready channel interfaces of the press counter: tick input, result output
// and configuration writes. Depends on psc_pkg for the payload widths.
`default_nettype none

interface psc_in_if;
    logic valid;
    logic ready;
    logic button_down;
    logic hold_tick;
    logic scan_tick;

    modport source (output valid, output button_down, output hold_tick,
                    output scan_tick, input ready);
    modport sink   (input valid, input button_down, input hold_tick,
                    input scan_tick, output ready);
endinterface

interface psc_out_if;
    logic                           valid;
    logic                           ready;
    logic [psc_pkg::SEG_W-1:0]      segments;
    logic [psc_pkg::POS_OUT_W-1:0]  digit_position;
    logic                           digit_lit;
    logic [psc_pkg::COUNT_W-1:0]    count_value;

    modport source (output valid, output segments, output digit_position,
                    output digit_lit, output count_value, input ready);
    modport sink   (input valid, input segments, input digit_position,
                    input digit_lit, input count_value, output ready);
endinterface

interface psc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [psc_pkg::REG_IDX_W-1:0]  reg_index;
    logic [psc_pkg::WDATA_W-1:0]    wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

// ===== sv/psc_press_ctrl.sv =====
// Button press tracking: press start, hold timing and release handling.
// Issues bump and clear commands to the digit chain. Depends on psc_pkg.
`default_nettype none

module psc_press_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        accept,
    input  wire logic                        button_down,
    input  wire logic                        hold_tick,
    input  wire logic [psc_pkg::HOLD_W-1:0]  hold_limit,
    output psc_pkg::psc_cmd_t                cmd
);
    import psc_pkg::*;

    logic [HOLD_W-1:0] hold_count_reg, hold_count_next;
    logic              cleared_reg, cleared_next;
    logic              was_pressed_reg;
    logic [HOLD_W-1:0] hold_base;
    logic              cleared_base;
    logic              do_clear;
    logic              do_bump;

    always_comb
    begin
        // A rising level starts a fresh press.
        hold_base       = was_pressed_reg ? hold_count_reg : '0;
        cleared_base    = was_pressed_reg ? cleared_reg : 1'b0;
        hold_count_next = hold_count_reg;
        cleared_next    = cleared_reg;
        do_clear        = 1'b0;
        do_bump         = 1'b0;
        if (button_down)
        begin
            hold_count_next = hold_base;
            cleared_next    = cleared_base;
            if (hold_tick && !cleared_base)
            begin
                if (hold_base != {HOLD_W{1'b1}})
                begin
                    hold_count_next = hold_base + HOLD_W'(1);
                end
                if (hold_count_next >= hold_limit)
                begin
                    do_clear     = 1'b1;
                    cleared_next = 1'b1;
                end
            end
        end
        else if (was_pressed_reg)
        begin
            do_bump         = !cleared_reg;
            hold_count_next = '0;
            cleared_next    = 1'b0;
        end
        cmd.bump  = accept && do_bump;
        cmd.clear = accept && do_clear;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_count_reg  <= '0;
            cleared_reg     <= 1'b0;
            was_pressed_reg <= 1'b0;
        end
        else if (accept)
        begin
            hold_count_reg  <= hold_count_next;
            cleared_reg     <= cleared_next;
            was_pressed_reg <= button_down;
        end
    end

endmodule

`default_nettype wire

// ===== sv/psc_digit_cell.sv =====
// One BCD digit of the counter chain: takes a carry from the digit below,
// passes a carry up and a nonzero flag down. Depends on psc_pkg.
`default_nettype none

module psc_digit_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         clear,
    input  wire logic                         carry_in,
    output logic                              carry_out,
    input  wire logic                         nz_in,
    output logic                              nz_out,
    output logic [psc_pkg::DIGIT_W-1:0]       digit_next
);
    import psc_pkg::*;

    logic [DIGIT_W-1:0] digit_reg;

    always_comb
    begin
        carry_out  = carry_in && (digit_reg >= DIGIT_MAX);
        digit_next = digit_reg;
        if (clear)
        begin
            digit_next = '0;
        end
        else if (carry_in)
        begin
            digit_next = (digit_reg >= DIGIT_MAX) ? '0 : digit_reg + DIGIT_W'(1);
        end
        // True when this digit or any digit above it is nonzero.
        nz_out = nz_in || (digit_next != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/press_counter_seg_display.sv =====
// Top level of the press counter with multiplexed seven-segment output.
// Depends on psc_pkg, psc_if, psc_press_ctrl and psc_digit_cell.
//
// Usage:
//   tick   : one beat per tick, carrying button_down, hold_tick and scan_tick.
//   result : exactly one beat per accepted tick, with the segment drive of the
//            scanned position, that position, its lit flag and the binary count.
//   cfg    : register writes, always ready. Index 0 is hold_limit (8 bits),
//            index 1 is blank_leading (bit 0). Write only while the block is idle.
// Timing:
//   A tick is handled in the cycle it is accepted; its result goes to the output
//   register, or to the skid entry while the output stalls. One tick is accepted per
//   cycle while tick.ready is high, as the digit cells' carry ripple is combinational.
// Stall behavior:
//   The output register is backed by one skid entry, so one more tick is taken
//   while a result waits. tick.ready drops only when the skid entry is full, and
//   no result is lost or repeated however long the receiver stalls.
// Reset:
//   rst_n clears the count, the press tracking, the scan position and both
//   output entries, and restores hold_limit to 20 and blank_leading to 1.
`default_nettype none

module press_counter_seg_display #(
    parameter int DIGITS = 4
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    psc_in_if.sink     tick,
    psc_out_if.source  result,
    psc_cfg_if.sink    cfg
);
    import psc_pkg::*;

    localparam int PW = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [PW-1:0] POS_LAST = PW'(DIGITS - 1);

    // Configuration registers.
    logic [HOLD_W-1:0] hold_limit_reg;
    logic              blank_leading_reg;

    // Counting and scanning.
    psc_cmd_t           press_cmd;
    logic               tick_accept;
    logic [DIGITS:0]    carry;
    logic [DIGITS-1:0]  nz_in;
    logic [DIGITS-1:0]  nz_out;
    logic [DIGIT_W-1:0] digit_next [DIGITS];
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [PW-1:0]      scan_pos_reg, scan_pos_next;
    logic [PW+1:0]      pos_ext;
    logic               lit;
    psc_result_t        res_new;

    // Output register and skid entry.
    logic        out_valid_reg;
    psc_result_t out_data_reg;
    logic        skid_valid_reg;
    psc_result_t skid_data_reg;

    assign tick.ready  = !skid_valid_reg;
    assign tick_accept = tick.valid && tick.ready;
    assign cfg.ready   = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_limit_reg    <= HOLD_LIMIT_RESET;
            blank_leading_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                REG_HOLD_LIMIT:    hold_limit_reg    <= cfg.wdata;
                REG_BLANK_LEADING: blank_leading_reg <= cfg.wdata[0];
                default:           ;
            endcase
        end
    end

    psc_press_ctrl u_press_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (tick_accept),
        .button_down (tick.button_down),
        .hold_tick   (tick.hold_tick),
        .hold_limit  (hold_limit_reg),
        .cmd         (press_cmd)
    );

    // The release bump enters the ones digit and ripples upward; the nonzero
    // flag for leading-zero blanking ripples down from the top digit.
    assign carry[0] = press_cmd.bump;

    for (genvar i = 0; i < DIGITS; i++)
    begin : g_cell
        if (i == DIGITS - 1)
        begin : g_top
            assign nz_in[i] = 1'b0;
        end
        else
        begin : g_mid
            assign nz_in[i] = nz_out[i+1];
        end

        psc_digit_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .clear      (press_cmd.clear),
            .carry_in   (carry[i]),
            .carry_out  (carry[i+1]),
            .nz_in      (nz_in[i]),
            .nz_out     (nz_out[i]),
            .digit_next (digit_next[i])
        );
    end

    // The binary count tracks the digits; a carry out of the top digit is the
    // wrap from all nines to zero.
    always_comb
    begin
        count_next = count_reg;
        if (press_cmd.clear)
        begin
            count_next = '0;
        end
        else if (press_cmd.bump)
        begin
            count_next = carry[DIGITS] ? '0 : count_reg + COUNT_W'(1);
        end
    end

    always_comb
    begin
        scan_pos_next = scan_pos_reg;
        if (tick.scan_tick)
        begin
            scan_pos_next = (scan_pos_reg == POS_LAST) ? '0 : scan_pos_reg + PW'(1);
        end
        pos_ext = {2'b00, scan_pos_next};
        // The ones position always shows.
        lit = (scan_pos_next == '0) || !blank_leading_reg || nz_out[scan_pos_next];
        res_new.segments       = lit ? psc_seg_code(digit_next[scan_pos_next]) : '0;
        res_new.digit_position = pos_ext[1:0];
        res_new.digit_lit      = lit;
        res_new.count_value    = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            scan_pos_reg <= '0;
        end
        else if (tick_accept)
        begin
            count_reg    <= count_next;
            scan_pos_reg <= scan_pos_next;
        end
    end

    // Output register with one skid entry behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= tick_accept;
            end
        end
        else if (tick_accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result.ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res_new;
        end
        else if (tick_accept)
        begin
            skid_data_reg <= res_new;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.segments       = out_data_reg.segments;
    assign result.digit_position = out_data_reg.digit_position;
    assign result.digit_lit      = out_data_reg.digit_lit;
    assign result.count_value    = out_data_reg.count_value;

    // The skid entry only fills behind a waiting output beat.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid while output register is empty");

    // A hold clear leaves the binary count at zero.
    a_clear_zeroes_count: assert property (@(posedge clk) disable iff (!rst_n)
        (tick_accept && press_cmd.clear) |=> (count_reg == '0))
        else $error("count not zero after a hold clear");

    // The scan position never leaves the digit row.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        scan_pos_reg <= POS_LAST)
        else $error("scan position beyond the last digit");

endmodule

`default_nettype wire

// ===== sim/tb_press_counter_seg_display.sv =====
// Self-checking testbench for press_counter_seg_display: directed and random tick beats
// are checked against a cycle-free model of the count, press tracking and digit scan.
// Depends on psc_pkg and the channel interfaces in psc_if.
`timescale 1ns / 100ps

module tb_press_counter_seg_display;

    import psc_pkg::*;

    localparam int NUM_DIGITS = 4;

    // Cycles with no beat on any channel before the run is declared hung. The
    // longest correct quiet stretch is a long sender gap or receiver stall drawn by
    // pause_len, or the short pause around a register write.
    localparam int IDLE_LIMIT = 2000;

    // Tick beats offered in each phase of the random test.
    localparam int PHASE_TICKS = 45;

    // Short presses in the counting climb.
    localparam int CLIMB_PRESSES = 50;

    // Ten seven-segment patterns, digit d at bits [7*d +: 7], segment a in bit 0.
    localparam logic [10*SEG_W-1:0] SEG_FONT = {
        7'h6f, 7'h7f, 7'h07, 7'h7d, 7'h6d, 7'h66, 7'h4f, 7'h5b, 7'h06, 7'h3f
    };

    logic clk;
    logic rst_n;

    psc_in_if  tick_if ();
    psc_out_if res_if ();
    psc_cfg_if cfg_if ();

    press_counter_seg_display #(
        .DIGITS (NUM_DIGITS)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    // Mirror of the block's state and registers, advanced once per accepted beat.
    logic [DIGIT_W-1:0] digit_mirror [NUM_DIGITS];
    logic [HOLD_W-1:0]  press_holds;
    bit                 press_cleared;
    bit                 button_was_down;
    logic [1:0]         shown_pos;
    logic [HOLD_W-1:0]  limit_mirror;
    bit                 blank_mirror;

    // Display beats that the block still owes, oldest first.
    psc_result_t display_q [$];

    int fail_count;
    int ticks_sent;
    int idle_cycles;

    // When set, neither side inserts gaps or stalls, so the block runs at full rate.
    bit steady_flow;

    always #2 clk = ~clk;

    // Binary value of the mirrored BCD count.
    function automatic int mirror_count();
        int value;
        value = 0;
        for (int i = NUM_DIGITS - 1; i >= 0; i--)
            value = value * 10 + int'(digit_mirror[i]);
        return value;
    endfunction

    // Advances the mirror by one tick and returns the display beat it causes.
    // The button is handled first, then the scan, and the beat shows the new
    // count at the new position.
    function automatic psc_result_t predict_display(bit down, bit hold, bit scan);
        psc_result_t r;
        bit          carry;
        bit          lit;
        if (down)
        begin
            // A new press starts its hold tally from zero.
            if (!button_was_down)
            begin
                press_holds   = '0;
                press_cleared = 1'b0;
            end
            if (hold && !press_cleared)
            begin
                if (press_holds != '1)
                    press_holds++;
                // A limit of zero clears on the first hold, just like a limit of one.
                if (press_holds >= limit_mirror)
                begin
                    foreach (digit_mirror[i])
                        digit_mirror[i] = '0;
                    press_cleared = 1'b1;
                end
            end
        end
        else if (button_was_down)
        begin
            // A release counts only if the press did not clear the count.
            if (!press_cleared)
            begin
                carry = 1'b1;
                for (int i = 0; i < NUM_DIGITS; i++)
                begin
                    if (carry)
                    begin
                        if (digit_mirror[i] >= DIGIT_MAX)
                            digit_mirror[i] = '0;
                        else
                        begin
                            digit_mirror[i] = digit_mirror[i] + 1'b1;
                            carry = 1'b0;
                        end
                    end
                end
            end
            press_holds   = '0;
            press_cleared = 1'b0;
        end
        button_was_down = down;

        if (scan)
            shown_pos = shown_pos + 2'd1;

        // The ones position always shows; a higher one shows when blanking is
        // off or when it or any position above it holds a nonzero digit.
        lit = (shown_pos == 2'd0) || !blank_mirror;
        for (int i = NUM_DIGITS - 1; i >= 0; i--)
        begin
            if (i >= int'(shown_pos) && digit_mirror[i] != '0)
                lit = 1'b1;
        end

        r.segments       = lit ? SEG_FONT[int'(digit_mirror[shown_pos]) * SEG_W +: SEG_W]
                               : '0;
        r.digit_position = shown_pos;
        r.digit_lit      = lit;
        r.count_value    = COUNT_W'(mirror_count());
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pause_len();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    // Register writes and tick beats are taken into the mirror at the edge that
    // accepts them. Writes only happen while no tick is in flight.
    always @(posedge clk)
    begin : mirror_update
        if (rst_n)
        begin
            if (cfg_if.valid && cfg_if.ready)
            begin
                if (cfg_if.reg_index == REG_HOLD_LIMIT)
                    limit_mirror = cfg_if.wdata;
                else if (cfg_if.reg_index == REG_BLANK_LEADING)
                    blank_mirror = cfg_if.wdata[0];
            end
            if (tick_if.valid && tick_if.ready)
                display_q.push_back(predict_display(tick_if.button_down,
                                                    tick_if.hold_tick,
                                                    tick_if.scan_tick));
        end
    end

    // Every accepted result beat is matched against the oldest owed beat.
    always @(posedge clk)
    begin : display_check
        psc_result_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (display_q.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: seg %h pos %0d lit %0d count %0d",
                         $time, res_if.segments, res_if.digit_position,
                         res_if.digit_lit, res_if.count_value);
                fail_count++;
            end
            else
            begin
                want = display_q.pop_front();
                if (res_if.segments !== want.segments)
                begin
                    $display("%0t: segments expected %h actual %h",
                             $time, want.segments, res_if.segments);
                    fail_count++;
                end
                if (res_if.digit_position !== want.digit_position)
                begin
                    $display("%0t: digit_position expected %0d actual %0d",
                             $time, want.digit_position, res_if.digit_position);
                    fail_count++;
                end
                if (res_if.digit_lit !== want.digit_lit)
                begin
                    $display("%0t: digit_lit expected %0d actual %0d",
                             $time, want.digit_lit, res_if.digit_lit);
                    fail_count++;
                end
                if (res_if.count_value !== want.count_value)
                begin
                    $display("%0t: count_value expected %0d actual %0d",
                             $time, want.count_value, res_if.count_value);
                    fail_count++;
                end
            end
        end
    end

    // The receiver alternates runs of ready with stalls of random length. In
    // steady flow it stays ready once the current stall has run out.
    always @(posedge clk)
    begin : result_stalls
        int run_left;
        if (run_left > 0)
            run_left--;
        else if (steady_flow || $urandom_range(0, 2) != 0)
        begin
            res_if.ready <= 1'b1;
            run_left = $urandom_range(1, 16);
        end
        else
        begin
            res_if.ready <= 1'b0;
            run_left = pause_len() - 1;
        end
    end

    // Ends a hung run: any beat on any channel restarts the count.
    always @(posedge clk)
    begin : watchdog
        if ((tick_if.valid && tick_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offers one tick beat, waits for it to be taken, then maybe leaves a gap.
    // Valid stays high across back-to-back beats.
    task automatic send_tick(input bit down, input bit hold, input bit scan);
        int gap;
        tick_if.valid       <= 1'b1;
        tick_if.button_down <= down;
        tick_if.hold_tick   <= hold;
        tick_if.scan_tick   <= scan;
        do
            @(posedge clk);
        while (!tick_if.ready);
        ticks_sent++;
        gap = (steady_flow || $urandom_range(0, 1) == 0) ? 0 : pause_len();
        if (gap > 0)
        begin
            tick_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // One press of len ticks, each with a hold strobe at the given odds, then
    // the release tick. Scan strobes fall at their own odds throughout.
    task automatic press_once(input int len, input int hold_pct, input int scan_pct);
        for (int i = 0; i < len; i++)
            send_tick(1'b1, $urandom_range(0, 99) < hold_pct,
                      $urandom_range(0, 99) < scan_pct);
        send_tick(1'b0, $urandom_range(0, 3) == 0, $urandom_range(0, 99) < scan_pct);
    endtask

    // Stops offering ticks and waits until every owed beat has come out, then
    // lets the output register and skid entry settle.
    task automatic wait_idle();
        tick_if.valid <= 1'b0;
        do
            @(posedge clk);
        while (display_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [WDATA_W-1:0] data);
        cfg_if.valid     <= 1'b1;
        cfg_if.reg_index <= idx;
        cfg_if.wdata     <= data;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Both registers are rewritten once the block has gone quiet. The unused
    // upper bits of the blanking write carry random values.
    task automatic set_config(input logic [HOLD_W-1:0] limit, input bit blank);
        logic [WDATA_W-1:0] blank_word;
        wait_idle();
        blank_word    = WDATA_W'($urandom);
        blank_word[0] = blank;
        write_reg(REG_HOLD_LIMIT, limit);
        write_reg(REG_BLANK_LEADING, blank_word);
    endtask

    // Right after reset the count is zero, so only the ones position shows;
    // the first scan strobe already moves to position one. A hold strobe with
    // the button up does nothing.
    task automatic test_blank_after_reset();
        send_tick(1'b0, 1'b0, 1'b0);
        repeat (4) send_tick(1'b0, 1'b0, 1'b1);
        send_tick(1'b0, 1'b1, 1'b1);
    endtask

    // Presses released below the hold limit each add one, including a press
    // that takes a hold strobe on its very first tick.
    task automatic test_short_presses();
        press_once(1, 0, 100);
        press_once(1, 100, 100);
        press_once(4, 50, 50);
        send_tick(1'b1, 1'b1, 1'b1);
        repeat (3) send_tick(1'b1, 1'b1, 1'b0);
        send_tick(1'b0, 1'b0, 1'b1);
    endtask

    // A press held to the limit clears the count at once; further hold strobes
    // and the release then leave it at zero. Limits of one and zero clear on
    // the first hold strobe.
    task automatic test_hold_clear();
        set_config(8'd3, 1'b1);
        press_once(2, 0, 50);
        press_once(5, 100, 50);
        press_once(1, 0, 50);
        set_config(8'd1, 1'b0);
        press_once(1, 0, 100);
        press_once(2, 100, 100);
        set_config(8'd0, 1'b0);
        press_once(1, 0, 100);
        press_once(1, 100, 100);
        press_once(1, 0, 100);
    endtask

    // With the largest limit a press of 254 hold strobes still counts and one
    // of 255 clears; extra strobes after the clear change nothing.
    task automatic test_hold_limit_max();
        set_config(8'hff, 1'b1);
        press_once(254, 100, 10);
        press_once(1, 0, 10);
        press_once(257, 100, 10);
    endtask

    // Climbs the count by a run of short presses with scans running, so carries
    // ripple into the upper digits and the blanking pattern follows them, then
    // shows every position with and without blanking.
    task automatic test_count_climb();
        set_config(HOLD_LIMIT_RESET, 1'b1);
        for (int n = 0; n < CLIMB_PRESSES; n++)
        begin
            // Half the climb runs at full rate.
            steady_flow = (n < CLIMB_PRESSES / 2);
            press_once(1, 0, 50);
        end
        steady_flow = 1'b0;
        repeat (4) send_tick(1'b0, 1'b0, 1'b1);
        set_config(HOLD_LIMIT_RESET, 1'b0);
        press_once(1, 0, 0);
        repeat (4) send_tick(1'b0, 1'b0, 1'b1);
        set_config(HOLD_LIMIT_RESET, 1'b1);
        repeat (4) send_tick(1'b0, 1'b0, 1'b1);
    endtask

    // Random presses of random length and hold density under a range of
    // register settings, with some ticks of pure noise mixed in.
    task automatic test_random_ticks();
        logic [HOLD_W-1:0] limits [8];
        int                phase_start;
        int                cap;
        limits = '{8'd1, 8'd2, 8'd4, 8'd7, 8'd12, 8'd0, 8'hff, 8'd3};
        limits[7] = HOLD_W'($urandom_range(1, 10));
        for (int p = 0; p < 8; p++)
        begin
            set_config(limits[p], p[0]);
            steady_flow = (p % 3 == 2);
            cap = (limits[p] == '0) ? 3 : int'(limits[p]) + 3;
            if (cap > 40)
                cap = 40;
            phase_start = ticks_sent;
            while (ticks_sent - phase_start < PHASE_TICKS)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    repeat ($urandom_range(0, 2))
                        send_tick(1'b0, 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
                    press_once($urandom_range(1, cap), $urandom_range(20, 100),
                               $urandom_range(10, 90));
                end
                else
                begin
                    repeat ($urandom_range(1, 4))
                        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  1'($urandom_range(0, 1)));
                end
            end
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        // Every input of the block is known from time zero.
        clk                 = 1'b0;
        rst_n               = 1'b0;
        tick_if.valid       = 1'b0;
        tick_if.button_down = 1'b0;
        tick_if.hold_tick   = 1'b0;
        tick_if.scan_tick   = 1'b0;
        res_if.ready        = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.reg_index    = '0;
        cfg_if.wdata        = '0;

        // The mirror starts from the block's reset state.
        foreach (digit_mirror[i])
            digit_mirror[i] = '0;
        press_holds     = '0;
        press_cleared   = 1'b0;
        button_was_down = 1'b0;
        shown_pos       = '0;
        limit_mirror    = HOLD_LIMIT_RESET;
        blank_mirror    = 1'b1;
        fail_count      = 0;
        ticks_sent      = 0;
        idle_cycles     = 0;
        steady_flow     = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_blank_after_reset();
        test_short_presses();
        test_hold_clear();
        test_hold_limit_max();
        test_random_ticks();
        test_count_climb();

        // All beats sent; wait for the last results and a few quiet cycles.
        wait_idle();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
